FILE: rtl/core/speech_segment_tracker_assert.svh
// Assertion macros for the speech segment tracker.
`ifndef SPEECH_SEGMENT_TRACKER_ASSERT_SVH
`define SPEECH_SEGMENT_TRACKER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sst: same-cycle check failed");
`define SST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sst: next-cycle check failed");
`else
`define SST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SST_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/sst_pkg.sv
// Shared types and constants for the speech segment tracker.
`timescale 1ns / 1ps
`default_nettype none
package sst_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int OUT_BITS          = 32;

    // 0.15 in Q0.16, rounded to nearest
    localparam logic [16:0] HYST_Q16 = 17'd9830;

    localparam logic [15:0] RST_SPEECH_THRESHOLD = 16'd32768;
    localparam logic [12:0] RST_WINDOW_SAMPLES   = 13'd512;
    localparam logic [15:0] RST_PAD_SAMPLES      = 16'd480;
    localparam logic [19:0] RST_MIN_SILENCE      = 20'd1600;
    localparam logic [19:0] RST_MIN_SPEECH       = 20'd4000;

    typedef enum logic [2:0] {
        REG_SPEECH_THRESHOLD = 3'd0,
        REG_WINDOW_SAMPLES   = 3'd1,
        REG_PAD_SAMPLES      = 3'd2,
        REG_MIN_SILENCE      = 3'd3,
        REG_MIN_SPEECH       = 3'd4
    } t_reg_idx;

    typedef enum logic {
        OP_WINDOW = 1'b0,
        OP_EOS    = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [15:0] speech_threshold;
        logic [12:0] window_samples;
        logic [15:0] pad_samples;
        logic [19:0] silence_hold;
        logic [19:0] length_floor;
    } t_cfg;

    typedef struct packed {
        logic                valid;
        logic [OUT_BITS-1:0] seg_start;
        logic [OUT_BITS-1:0] seg_end;
    } t_seg_result;

endpackage
`default_nettype wire

FILE: rtl/core/speech_segment_tracker.sv
// Top level of the speech segment tracker: stream stages, state and config.
// An accepted item lands in the input register and then moves on to the result
//   register that drives o_m_tvalid; a result not yet taken by the sink holds it.
// Throughput: one item per cycle while no result waits on the sink; set by the state update loop.
// Reset (i_rst_n low at a clock edge, synchronous): tracker state cleared,
//   both stream stages emptied, registers back to their default values.
`timescale 1ns / 1ps
`default_nettype none
module speech_segment_tracker #(
    parameter int POSITION_BITS = sst_pkg::POSITION_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // config port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // input items
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [47:0]  i_s_tdata,  // [15:0] probability, [47:16] stream_length
    input  wire logic         i_s_tuser,  // [0] opcode
    // result items
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [63:0]       o_m_tdata   // [31:0] segment_start, [63:32] segment_end
);
    import sst_pkg::*;
    `include "speech_segment_tracker_assert.svh"

    localparam int P = POSITION_BITS;

    t_cfg        cfg;
    t_seg_result seg_res;

    // input register
    logic         r_in_vld;
    logic         r_in_op;
    logic [15:0]  r_in_prob;
    logic [31:0]  r_in_len;

    // tracker state
    logic         r_in_speech;
    logic [P-1:0] r_pos;
    logic [P-1:0] r_tent;
    logic [P-1:0] r_open;
    logic         n_in_speech;
    logic [P-1:0] n_pos;
    logic [P-1:0] n_tent;
    logic [P-1:0] n_open;

    // result register
    logic         r_out_vld;
    logic [63:0]  r_out_data;

    logic         adv;
    logic         adv_eos;
    logic         adv_win;

    // item moves from input register into state/result when result slot frees
    assign adv        = r_in_vld & (~r_out_vld | i_m_tready);
    assign o_s_tready = ~r_in_vld | adv;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    // advance split by item kind
    assign adv_eos = adv & (r_in_op == OP_EOS);
    assign adv_win = adv & (r_in_op == OP_WINDOW);

    sst_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sst_seg_logic #(
        .POSITION_BITS (POSITION_BITS)
    ) u_seg (
        .i_cfg           (cfg),
        .i_opcode        (r_in_op),
        .i_probability   (r_in_prob),
        .i_stream_length (r_in_len),
        .i_in_speech     (r_in_speech),
        .i_pos           (r_pos),
        .i_tent          (r_tent),
        .i_open          (r_open),
        .o_in_speech     (n_in_speech),
        .o_pos           (n_pos),
        .o_tent          (n_tent),
        .o_open          (n_open),
        .o_result        (seg_res)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_op   <= i_s_tuser;
            r_in_prob <= i_s_tdata[15:0];
            r_in_len  <= i_s_tdata[47:16];
        end
    end

    // tracker state, updated once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_speech <= 1'b0;
            r_pos       <= '0;
            r_tent      <= '0;
            r_open      <= '0;
        end else if (adv) begin
            r_in_speech <= n_in_speech;
            r_pos       <= n_pos;
            r_tent      <= n_tent;
            r_open      <= n_open;
        end
    end

    // result stage; only items that close a long enough segment show up here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= seg_res.valid;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && seg_res.valid) begin
            r_out_data <= {seg_res.seg_end, seg_res.seg_start};
        end
    end

    // no silence timer outside a segment
    `SST_ASSERT_IMP(a_tent_idle, i_clk, i_rst_n, !r_in_speech, r_tent == '0)
    // end of stream wipes the tracker
    `SST_ASSERT_NXT(a_eos_clear, i_clk, i_rst_n, adv_eos, ~|{r_in_speech, r_pos, r_open})
    // position only moves forward on window items
    `SST_ASSERT_NXT(a_pos_mono, i_clk, i_rst_n, adv_win, r_pos >= $past(r_pos))
    // back-pressure only when both stages are full and the sink stalls
    `SST_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !o_s_tready, r_in_vld && r_out_vld && !i_m_tready)

endmodule
`default_nettype wire

FILE: rtl/core/sst_cfg_regs.sv
// APB-style configuration register file for the speech segment tracker.
`timescale 1ns / 1ps
`default_nettype none
module sst_cfg_regs (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output sst_pkg::t_cfg     o_cfg
);
    import sst_pkg::*;

    t_cfg        r_cfg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speech_threshold <= RST_SPEECH_THRESHOLD;
            r_cfg.window_samples   <= RST_WINDOW_SAMPLES;
            r_cfg.pad_samples      <= RST_PAD_SAMPLES;
            r_cfg.silence_hold     <= RST_MIN_SILENCE;
            r_cfg.length_floor     <= RST_MIN_SPEECH;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SPEECH_THRESHOLD: r_cfg.speech_threshold <= pwdata[15:0];
                REG_WINDOW_SAMPLES:   r_cfg.window_samples   <= pwdata[12:0];
                REG_PAD_SAMPLES:      r_cfg.pad_samples      <= pwdata[15:0];
                REG_MIN_SILENCE:      r_cfg.silence_hold     <= pwdata[19:0];
                REG_MIN_SPEECH:       r_cfg.length_floor     <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SPEECH_THRESHOLD: prdata = 32'(r_cfg.speech_threshold);
            REG_WINDOW_SAMPLES:   prdata = 32'(r_cfg.window_samples);
            REG_PAD_SAMPLES:      prdata = 32'(r_cfg.pad_samples);
            REG_MIN_SILENCE:      prdata = 32'(r_cfg.silence_hold);
            REG_MIN_SPEECH:       prdata = 32'(r_cfg.length_floor);
            default:              prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/core/sst_seg_logic.sv
// Per-item segmentation logic: next tracker state and optional segment.
`timescale 1ns / 1ps
`default_nettype none
module sst_seg_logic #(
    parameter int POSITION_BITS = sst_pkg::POSITION_BITS_DEF
) (
    input  wire sst_pkg::t_cfg          i_cfg,
    input  wire logic                   i_opcode,
    input  wire logic [15:0]            i_probability,
    input  wire logic [31:0]            i_stream_length,
    input  wire logic                   i_in_speech,
    input  wire logic [POSITION_BITS-1:0] i_pos,
    input  wire logic [POSITION_BITS-1:0] i_tent,
    input  wire logic [POSITION_BITS-1:0] i_open,
    output logic                        o_in_speech,
    output logic [POSITION_BITS-1:0]    o_pos,
    output logic [POSITION_BITS-1:0]    o_tent,
    output logic [POSITION_BITS-1:0]    o_open,
    output sst_pkg::t_seg_result        o_result
);
    import sst_pkg::*;

    localparam int P  = POSITION_BITS;
    localparam int XW = P + 2;                              // signed offset math
    localparam int EW = ((P > OUT_BITS) ? P : OUT_BITS) + 3; // length test
    localparam int CW = (P > 20) ? P : 20;                  // silence compare
    localparam logic [P-1:0] POS_MAX = {P{1'b1}};

    logic [P:0]    pos_sum;
    logic [P-1:0]  pos_new;
    logic [XW-1:0] s_ext;
    logic [P-1:0]  open_new;
    logic          is_speech;
    logic          is_quiet;
    logic [P-1:0]  tent_eff;
    logic [P-1:0]  silence;
    logic          sil_done;
    logic [XW-1:0] e_ext;
    logic [P-1:0]  end_clamp;
    logic [EW-1:0] rep_end;
    logic [EW-1:0] rep_start;
    logic [EW-1:0] seg_len;
    logic          len_ok;
    logic          is_eos;

    assign is_eos = (i_opcode == OP_EOS);

    // saturating position advance
    assign pos_sum = {1'b0, i_pos} + (P+1)'(i_cfg.window_samples);
    assign pos_new = pos_sum[P] ? POS_MAX : pos_sum[P-1:0];

    // padded start, clamped at zero
    assign s_ext    = XW'(pos_new) - XW'(i_cfg.pad_samples) - XW'(i_cfg.window_samples);
    assign open_new = s_ext[XW-1] ? '0 : s_ext[P-1:0];

    assign is_speech = (i_probability >= i_cfg.speech_threshold);
    assign is_quiet  = (({1'b0, i_probability} + HYST_Q16) < {1'b0, i_cfg.speech_threshold});

    // zero tentative end means no silence pending
    assign tent_eff = (i_tent == '0) ? pos_new : i_tent;
    assign silence  = (pos_new >= tent_eff) ? (pos_new - tent_eff) : '0;
    assign sil_done = (CW'(silence) >= CW'(i_cfg.silence_hold));

    // padded end, clamped to the position range
    assign e_ext     = XW'(tent_eff) + XW'(i_cfg.pad_samples) - XW'(i_cfg.window_samples);
    assign end_clamp = e_ext[XW-1] ? '0 : (e_ext[P] ? POS_MAX : e_ext[P-1:0]);

    // unpadded length test, signed
    assign rep_start = EW'(i_open);
    assign rep_end   = is_eos ? EW'(i_stream_length) : EW'(end_clamp);
    assign seg_len   = rep_end - EW'(i_cfg.pad_samples) - rep_start
                     - EW'(i_cfg.pad_samples);
    assign len_ok    = ($signed(seg_len) >= $signed(EW'(i_cfg.length_floor)));

    always_comb begin
        o_in_speech = i_in_speech;
        o_pos       = i_pos;
        o_tent      = i_tent;
        o_open      = i_open;
        o_result.valid     = 1'b0;
        o_result.seg_start = (rep_start > EW'({OUT_BITS{1'b1}})) ?
                             {OUT_BITS{1'b1}} : rep_start[OUT_BITS-1:0];
        o_result.seg_end   = (rep_end > EW'({OUT_BITS{1'b1}})) ?
                             {OUT_BITS{1'b1}} : rep_end[OUT_BITS-1:0];
        if (is_eos) begin
            o_result.valid = i_in_speech & len_ok;
            o_in_speech    = 1'b0;
            o_pos          = '0;
            o_tent         = '0;
            o_open         = '0;
        end else begin
            o_pos = pos_new;
            if (is_speech) begin
                o_tent = '0;
                if (!i_in_speech) begin
                    o_in_speech = 1'b1;
                    o_open      = open_new;
                end
            end else if (i_in_speech && is_quiet) begin
                if (sil_done) begin
                    o_result.valid = len_ok;
                    o_tent         = '0;
                    o_in_speech    = 1'b0;
                end else begin
                    o_tent = tent_eff;
                end
            end
        end
    end

endmodule
`default_nettype wire
